// File: hw/rtl/cca_pkg.sv
// Calendar clock adder package: field widths, reset values and month lengths.
// Used by calendar_clock_adder, its checker and the testbench; no dependencies.
`default_nettype none

package cca_pkg;

  localparam int unsigned TenthsW  = 4;
  localparam int unsigned SecondsW = 6;
  localparam int unsigned MinutesW = 6;
  localparam int unsigned HoursW   = 5;
  localparam int unsigned DayW     = 5;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned YearW    = 14;
  localparam int unsigned YrPartW  = 7;   // year split in centuries and year of century

  localparam int unsigned InDataW  = 24;  // 21 bits of fields, zero filled
  localparam int unsigned OutDataW = 48;  // 45 bits of fields, zero filled

  localparam logic [TenthsW-1:0]  TenthsMax  = 4'd9;
  localparam logic [SecondsW-1:0] SecondsMax = 6'd59;
  localparam logic [MinutesW-1:0] MinutesMax = 6'd59;
  localparam logic [HoursW-1:0]   HoursMax   = 5'd23;
  localparam logic [MonthW-1:0]   MonthMax   = 4'd12;
  localparam logic [YearW-1:0]    YearMax    = 14'd9999;
  localparam logic [YrPartW-1:0]  YrPartMax  = 7'd99;

  localparam logic [DayW-1:0]    ResetDay   = 5'd1;
  localparam logic [MonthW-1:0]  ResetMonth = 4'd9;
  localparam logic [YearW-1:0]   ResetYear  = 14'd2019;
  localparam logic [YrPartW-1:0] ResetYrLo  = 7'd19;
  localparam logic [YrPartW-1:0] ResetYrHi  = 7'd20;

  typedef struct packed {
    logic [TenthsW-1:0]  tenths;
    logic [SecondsW-1:0] seconds;
    logic [MinutesW-1:0] minutes;
    logic [HoursW-1:0]   hours;
    logic [DayW-1:0]     day;
    logic [MonthW-1:0]   month;
    logic [YearW-1:0]    year;
  } clock_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                input logic leap);
    logic [DayW-1:0] len;
    unique case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/calendar_clock_adder.sv
// Calendar clock adder: adds a time span to a calendar clock, rolls the date.
// Result valid the cycle after input transfer; one transfer per cycle unless stalled.
// The whole carry chain and date roll sit between the clock state and the result register.
// Input is taken while the result register is empty or its result is being taken.
// Reset (rst_ni low, asynchronous) sets 2019-09-01 00:00:00.0 and empties the result.
// Depends on cca_pkg.
`default_nettype none

module calendar_clock_adder (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // add_hours[4:0], add_minutes[10:5], add_seconds[16:11], add_tenths[20:17]
  input  wire logic [cca_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // out_tenths[3:0], out_seconds[9:4], out_minutes[15:10], out_hours[20:16],
  // out_day[25:21], out_month[29:26], out_year[43:30], date_advanced[44]
  output logic [cca_pkg::OutDataW-1:0]      m_axis_tdata
);

  cca_pkg::clock_t cur_q, cur_d;
  logic [cca_pkg::YrPartW-1:0] yr_lo_q, yr_lo_d, yr_hi_q, yr_hi_d;
  logic                        out_valid_q;
  cca_pkg::clock_t             res_q;
  logic                        res_adv_q, adv_d;
  logic                        accept;

  logic [cca_pkg::HoursW-1:0]   in_h;
  logic [cca_pkg::MinutesW-1:0] in_m;
  logic [cca_pkg::SecondsW-1:0] in_s;
  logic [cca_pkg::TenthsW-1:0]  in_t;
  logic [4:0] t_sum;
  logic [6:0] s_sum, m_sum;
  logic [5:0] h_sum;
  logic       c_t, c_s, c_m, c_h;
  logic       leap;
  logic [cca_pkg::DayW-1:0] len;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_h = s_axis_tdata[4:0];
    in_m = s_axis_tdata[10:5];
    in_s = s_axis_tdata[16:11];
    in_t = s_axis_tdata[20:17];
    if (in_h > cca_pkg::HoursMax)   in_h = cca_pkg::HoursMax;
    if (in_m > cca_pkg::MinutesMax) in_m = cca_pkg::MinutesMax;
    if (in_s > cca_pkg::SecondsMax) in_s = cca_pkg::SecondsMax;
    if (in_t > cca_pkg::TenthsMax)  in_t = cca_pkg::TenthsMax;

    cur_d   = cur_q;
    yr_lo_d = yr_lo_q;
    yr_hi_d = yr_hi_q;

    t_sum = {1'b0, cur_q.tenths} + {1'b0, in_t};
    c_t   = t_sum >= 5'd10;
    cur_d.tenths = c_t ? 4'(t_sum - 5'd10) : t_sum[3:0];

    s_sum = {1'b0, cur_q.seconds} + {1'b0, in_s} + {6'd0, c_t};
    c_s   = s_sum >= 7'd60;
    cur_d.seconds = c_s ? 6'(s_sum - 7'd60) : s_sum[5:0];

    m_sum = {1'b0, cur_q.minutes} + {1'b0, in_m} + {6'd0, c_s};
    c_m   = m_sum >= 7'd60;
    cur_d.minutes = c_m ? 6'(m_sum - 7'd60) : m_sum[5:0];

    h_sum = {1'b0, cur_q.hours} + {1'b0, in_h} + {5'd0, c_m};
    c_h   = h_sum >= 6'd24;
    cur_d.hours = c_h ? 5'(h_sum - 6'd24) : h_sum[4:0];

    // Gregorian leap rule on the split year
    leap = ((yr_lo_q[1:0] == 2'd0) && (yr_lo_q != '0))
        || ((yr_lo_q == '0) && (yr_hi_q[1:0] == 2'd0));
    len  = cca_pkg::month_len(cur_q.month, leap);
    adv_d = c_h;

    if (c_h) begin
      if (cur_q.day >= len) begin
        cur_d.day = 5'd1;
        if (cur_q.month >= cca_pkg::MonthMax) begin
          cur_d.month = 4'd1;
          cur_d.year  = (cur_q.year == cca_pkg::YearMax) ? '0 : cur_q.year + 14'd1;
          if (yr_lo_q == cca_pkg::YrPartMax) begin
            yr_lo_d = '0;
            yr_hi_d = (yr_hi_q == cca_pkg::YrPartMax) ? '0 : yr_hi_q + 7'd1;
          end else begin
            yr_lo_d = yr_lo_q + 7'd1;
          end
        end else begin
          cur_d.month = cur_q.month + 4'd1;
        end
      end else begin
        cur_d.day = cur_q.day + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q.tenths  <= '0;
      cur_q.seconds <= '0;
      cur_q.minutes <= '0;
      cur_q.hours   <= '0;
      cur_q.day     <= cca_pkg::ResetDay;
      cur_q.month   <= cca_pkg::ResetMonth;
      cur_q.year    <= cca_pkg::ResetYear;
      yr_lo_q       <= cca_pkg::ResetYrLo;
      yr_hi_q       <= cca_pkg::ResetYrHi;
      out_valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        cur_q   <= cur_d;
        yr_lo_q <= yr_lo_d;
        yr_hi_q <= yr_hi_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q     <= cur_d;
      res_adv_q <= adv_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, res_adv_q, res_q.year, res_q.month, res_q.day,
                          res_q.hours, res_q.minutes, res_q.seconds, res_q.tenths};

endmodule

`default_nettype wire

// File: hw/rtl/cca_checker.sv
// Port-level checker for calendar_clock_adder, attached by bind.
// Depends on cca_pkg.
`default_nettype none

module cca_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        s_axis_tvalid,
  input wire logic                        s_axis_tready,
  input wire logic [cca_pkg::InDataW-1:0] s_axis_tdata,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [cca_pkg::OutDataW-1:0] m_axis_tdata
);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // result held while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // empty output stage never blocks the input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> m_axis_tvalid)
    else $error("no result one cycle after input transfer");

  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid |-> !$isunknown(s_axis_tdata))
    else $error("unknown input data while valid");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[3:0] <= 4'd9) && (m_axis_tdata[9:4] <= 6'd59)
      && (m_axis_tdata[15:10] <= 6'd59) && (m_axis_tdata[20:16] <= 5'd23)
      && (m_axis_tdata[25:21] != 5'd0) && (m_axis_tdata[29:26] != 4'd0)
      && (m_axis_tdata[29:26] <= 4'd12) && (m_axis_tdata[43:30] <= 14'd9999))
    else $error("clock field out of range");

endmodule

bind calendar_clock_adder cca_checker u_cca_checker (.*);

`default_nettype wire

// File: verif/tb_top.sv
// Testbench for calendar_clock_adder: random and directed time spans go in over the input
// stream, and an internal clock and calendar model checks every result transfer.
// Depends on cca_pkg and calendar_clock_adder.

module tb_top;

  localparam int unsigned NumRandom  = 850;
  localparam int unsigned CalmTail   = 100;
  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned MaxPrints  = 40;

  typedef struct packed {
    logic [cca_pkg::TenthsW-1:0]  tenths;
    logic [cca_pkg::SecondsW-1:0] seconds;
    logic [cca_pkg::MinutesW-1:0] minutes;
    logic [cca_pkg::HoursW-1:0]   hours;
  } span_t;

  typedef struct packed {
    logic                         adv;
    logic [cca_pkg::YearW-1:0]    year;
    logic [cca_pkg::MonthW-1:0]   month;
    logic [cca_pkg::DayW-1:0]     day;
    logic [cca_pkg::HoursW-1:0]   hours;
    logic [cca_pkg::MinutesW-1:0] minutes;
    logic [cca_pkg::SecondsW-1:0] seconds;
    logic [cca_pkg::TenthsW-1:0]  tenths;
  } stamp_t;

  logic                         clk_i   = 1'b0;
  logic                         rst_ni  = 1'b0;
  logic                         s_valid = 1'b0;
  logic                         s_ready;
  logic [cca_pkg::InDataW-1:0]  s_data  = '0;
  logic                         m_valid;
  logic                         m_ready = 1'b1;
  logic [cca_pkg::OutDataW-1:0] m_data;

  span_t       span_q[$];
  stamp_t      clock_exp_q[$];
  int unsigned err_cnt   = 0;
  int unsigned cycles    = 0;
  int unsigned in_gap    = 0;
  int unsigned stall_cnt = 0;
  logic        calm      = 1'b0;

  // model of the calendar clock
  int unsigned now_tenths  = 0;
  int unsigned now_seconds = 0;
  int unsigned now_minutes = 0;
  int unsigned now_hours   = 0;
  int unsigned now_day     = 32'(cca_pkg::ResetDay);
  int unsigned now_month   = 32'(cca_pkg::ResetMonth);
  int unsigned now_year    = 32'(cca_pkg::ResetYear);

  calendar_clock_adder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string msg);
    err_cnt++;
    if (err_cnt <= MaxPrints) $display("mismatch @%0d: %s", cycles, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned exp);
    if (got != exp) report($sformatf("%s got %0d exp %0d", name, got, exp));
  endtask

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(input int unsigned m, input bit leap);
    int unsigned dim [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m == 2 && leap) return 29;
    return dim[m-1];
  endfunction

  function automatic int unsigned sat(input int unsigned v, input int unsigned top);
    return (v > top) ? top : v;
  endfunction

  // Adds v into one unit, wraps at md; returns the carry out.
  function automatic int unsigned add_wrap(inout int unsigned unit, input int unsigned v,
                                           input int unsigned md);
    int unsigned s;
    s = unit + v;
    if (s >= md) begin
      unit = s - md;
      return 1;
    end
    unit = s;
    return 0;
  endfunction

  task automatic advance_clock(input span_t sp);
    int unsigned c;
    int unsigned m;
    stamp_t      st;
    c = add_wrap(now_tenths, sat(32'(sp.tenths), 32'(cca_pkg::TenthsMax)),
                 cca_pkg::TenthsMax + 1);
    c = add_wrap(now_seconds, sat(32'(sp.seconds), 32'(cca_pkg::SecondsMax)) + c,
                 cca_pkg::SecondsMax + 1);
    c = add_wrap(now_minutes, sat(32'(sp.minutes), 32'(cca_pkg::MinutesMax)) + c,
                 cca_pkg::MinutesMax + 1);
    c = add_wrap(now_hours, sat(32'(sp.hours), 32'(cca_pkg::HoursMax)) + c,
                 cca_pkg::HoursMax + 1);
    if (c != 0) begin
      m = (now_month < 1 || now_month > cca_pkg::MonthMax) ? 1 : now_month;
      if (now_day >= month_days(m, leap_year(now_year))) begin
        now_day = 1;
        if (m >= cca_pkg::MonthMax) begin
          now_month = 1;
          now_year  = (now_year + 1) % (cca_pkg::YearMax + 1);
        end else begin
          now_month = m + 1;
        end
      end else begin
        now_day++;
      end
    end
    st.tenths  = now_tenths[cca_pkg::TenthsW-1:0];
    st.seconds = now_seconds[cca_pkg::SecondsW-1:0];
    st.minutes = now_minutes[cca_pkg::MinutesW-1:0];
    st.hours   = now_hours[cca_pkg::HoursW-1:0];
    st.day     = now_day[cca_pkg::DayW-1:0];
    st.month   = now_month[cca_pkg::MonthW-1:0];
    st.year    = now_year[cca_pkg::YearW-1:0];
    st.adv     = (c != 0);
    clock_exp_q.push_back(st);
  endtask

  function automatic void queue_span(input int unsigned h, input int unsigned mi,
                                     input int unsigned s, input int unsigned t);
    span_t sp;
    sp.hours   = h[cca_pkg::HoursW-1:0];
    sp.minutes = mi[cca_pkg::MinutesW-1:0];
    sp.seconds = s[cca_pkg::SecondsW-1:0];
    sp.tenths  = t[cca_pkg::TenthsW-1:0];
    span_q.push_back(sp);
  endfunction

  // input side
  always @(posedge clk_i) begin : drive_spans
    span_t nxt;
    if (rst_ni) begin
      if (s_valid && s_ready) advance_clock(span_t'(s_data[20:0]));
      calm <= (span_q.size() <= CalmTail);
      if (!s_valid || s_ready) begin
        if (in_gap != 0) begin
          in_gap  <= in_gap - 1;
          s_valid <= 1'b0;
        end else if (span_q.size() != 0) begin
          nxt = span_q.pop_front();
          s_valid <= 1'b1;
          s_data  <= {3'b000, nxt};
          if (!calm && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 14);
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk_i) begin : watch_results
    stamp_t got;
    stamp_t exp;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        got = m_data[44:0];
        if (clock_exp_q.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          exp = clock_exp_q.pop_front();
          check_field("tenths", 32'(got.tenths), 32'(exp.tenths));
          check_field("seconds", 32'(got.seconds), 32'(exp.seconds));
          check_field("minutes", 32'(got.minutes), 32'(exp.minutes));
          check_field("hours", 32'(got.hours), 32'(exp.hours));
          check_field("day", 32'(got.day), 32'(exp.day));
          check_field("month", 32'(got.month), 32'(exp.month));
          check_field("year", 32'(got.year), 32'(exp.year));
          check_field("date_advanced", 32'(got.adv), 32'(exp.adv));
        end
      end
      if (stall_cnt != 0) begin
        stall_cnt <= stall_cnt - 1;
        m_ready   <= (stall_cnt == 1);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_cnt <= $urandom_range(1, 14);
        m_ready   <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned pick;
    // directed: zero span, tick, carries, legal maxima, saturation
    queue_span(0, 0, 0, 0);
    queue_span(0, 0, 0, 1);
    queue_span(0, 0, 0, 9);
    queue_span(0, 0, 59, 9);
    queue_span(0, 59, 59, 9);
    queue_span(23, 59, 59, 9);
    queue_span(31, 63, 63, 15);
    queue_span(24, 0, 0, 0);
    queue_span(0, 60, 0, 0);
    queue_span(0, 0, 60, 0);
    queue_span(0, 0, 0, 10);
    queue_span(16, 32, 32, 8);
    queue_span(15, 31, 31, 7);
    queue_span(23, 0, 0, 0);
    queue_span(23, 59, 59, 9);
    for (int i = 0; i < 6; i++) queue_span(23, 59, 59, 9);
    // random: mostly near-day spans so the calendar walks through months and a leap Feb
    for (int unsigned i = 0; i < NumRandom; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        queue_span($urandom_range(20, 23), $urandom_range(0, 59),
                   $urandom_range(0, 59), $urandom_range(0, 9));
      end else if (pick < 9) begin
        queue_span($urandom_range(0, 31), $urandom_range(0, 63),
                   $urandom_range(0, 63), $urandom_range(0, 15));
      end else begin
        queue_span(0, $urandom_range(0, 1), $urandom_range(0, 3), $urandom_range(1, 9));
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (span_q.size() != 0 || s_valid) @(posedge clk_i);
    while (clock_exp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/cca_pkg.sv
hw/rtl/calendar_clock_adder.sv
hw/rtl/cca_checker.sv
verif/tb_top.sv
